// ----- hdl/mwm_pkg.sv -----
package mwm_pkg;

    // lane count and field widths
    localparam int Lanes    = 4;
    localparam int CmdW     = 8;
    localparam int WheelW   = 10;
    localparam int MagW     = 9;
    localparam int LimitW   = 9;
    localparam int GainW    = 16;
    localparam int DbW      = 17;
    localparam int DirW     = 2;
    localparam int RpsW     = 25;
    localparam int FracW    = 8;

    // divider geometry: numerator is |w| * limit (|w| alone when not limiting), implicitly shifted by FracW
    localparam int NumW     = 18;
    localparam int DenW     = 9;
    localparam int QuotW    = NumW - DenW + FracW;
    localparam int DivSteps = QuotW;
    localparam int ProdW    = QuotW + GainW;

    // stream and config port widths
    localparam int InDataW  = 32;
    localparam int OutDataW = 112;
    localparam int OutPadW  = OutDataW - Lanes * (DirW + RpsW);
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 17;

    // register reset values
    localparam logic [LimitW-1:0] LimitRst = 9'd100;
    localparam logic [GainW-1:0]  GainRst  = 16'd256;
    localparam logic [DbW-1:0]    DbRst    = 17'd25;

    // output saturation bound
    localparam logic [RpsW-1:0] RpsMax = 25'd19660500;

    // wheel direction codes
    localparam logic [DirW-1:0] DirStop = 2'b00;
    localparam logic [DirW-1:0] DirFwd  = 2'b01;
    localparam logic [DirW-1:0] DirRev  = 2'b11;

    // config register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CfgSpeedLimit = 2'd0,
        CfgRpsGain    = 2'd1,
        CfgDeadband   = 2'd2
    } cfg_idx_t;

    typedef logic [Lanes-1:0][WheelW-1:0] wheel_vec_t;
    typedef logic [Lanes-1:0][MagW-1:0]   mag_vec_t;
    typedef logic [Lanes-1:0][NumW-1:0]   num_vec_t;
    typedef logic [Lanes-1:0][DenW-1:0]   rem_vec_t;
    typedef logic [Lanes-1:0][QuotW-1:0]  quot_vec_t;
    typedef logic [Lanes-1:0][DirW-1:0]   dir_vec_t;
    typedef logic [Lanes-1:0][RpsW-1:0]   rps_vec_t;

    // side information that travels with each word
    typedef struct packed {
        logic             en;
        logic [Lanes-1:0] neg;
    } mwm_ctl_t;

endpackage

// ----- hdl/mwm_front.sv -----
module mwm_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_enable,
    input  logic signed [mwm_pkg::CmdW-1:0]  in_vx,
    input  logic signed [mwm_pkg::CmdW-1:0]  in_vy,
    input  logic signed [mwm_pkg::CmdW-1:0]  in_vw,
    input  logic [mwm_pkg::LimitW-1:0]       speed_limit,
    output logic                             out_valid,
    input  logic                             out_ready,
    output mwm_pkg::mwm_ctl_t                out_ctl,
    output mwm_pkg::num_vec_t                out_num,
    output logic [mwm_pkg::DenW-1:0]         out_den
);
    import mwm_pkg::*;

    logic vld_a_reg, vld_b_reg, vld_c_reg;
    logic vld_a_next, vld_b_next, vld_c_next;
    logic rdy_a, rdy_b, rdy_c;

    logic       en_a_reg, en_a_next;
    wheel_vec_t w_reg, w_next;

    logic             en_b_reg, en_b_next;
    logic [Lanes-1:0] neg_b_reg, neg_b_next;
    mag_vec_t         abs_reg, abs_next;
    logic [MagW-1:0]  max01_reg, max01_next, max23_reg, max23_next;

    mwm_ctl_t         ctl_c_reg, ctl_c_next;
    num_vec_t         num_c_reg, num_c_next;
    logic [DenW-1:0]  den_c_reg, den_c_next;

    // ready chain, each stage fills when empty or draining
    assign rdy_c    = !vld_c_reg || out_ready;
    assign rdy_b    = !vld_b_reg || rdy_c;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_ready = rdy_a;

    assign vld_a_next = rdy_a ? in_valid  : vld_a_reg;
    assign vld_b_next = rdy_b ? vld_a_reg : vld_b_reg;
    assign vld_c_next = rdy_c ? vld_b_reg : vld_c_reg;

    // stage a: wheel sums and differences
    always_comb
    begin
        logic signed [WheelW-1:0] x;
        logic signed [WheelW-1:0] y;
        logic signed [WheelW-1:0] r;
        x = WheelW'(in_vx);
        y = WheelW'(in_vy);
        r = WheelW'(in_vw);
        en_a_next = in_enable;
        w_next[0] = x + y + r;
        w_next[1] = x - y - r;
        w_next[2] = x - y + r;
        w_next[3] = x + y - r;
    end

    // stage b: magnitudes, signs and pairwise maxima
    always_comb
    begin
        logic [WheelW-1:0] wneg;
        en_b_next = en_a_reg;
        for (int i = 0; i < Lanes; i++)
        begin
            wneg          = WheelW'(0) - w_reg[i];
            neg_b_next[i] = w_reg[i][WheelW-1];
            abs_next[i]   = neg_b_next[i] ? wneg[MagW-1:0] : w_reg[i][MagW-1:0];
        end
        max01_next = (abs_next[0] > abs_next[1]) ? abs_next[0] : abs_next[1];
        max23_next = (abs_next[2] > abs_next[3]) ? abs_next[2] : abs_next[3];
    end

    // stage c: overall maximum, limit check and divider operands
    always_comb
    begin
        logic [MagW-1:0] maxv;
        logic            scale;
        maxv  = (max01_reg > max23_reg) ? max01_reg : max23_reg;
        scale = maxv > speed_limit;
        for (int i = 0; i < Lanes; i++)
        begin
            num_c_next[i] = scale ? NumW'(abs_reg[i]) * NumW'(speed_limit)
                                  : NumW'(abs_reg[i]);
        end
        den_c_next     = scale ? DenW'(maxv) : DenW'(1);
        ctl_c_next.en  = en_b_reg;
        ctl_c_next.neg = neg_b_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else
        begin
            vld_a_reg <= vld_a_next;
            vld_b_reg <= vld_b_next;
            vld_c_reg <= vld_c_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            en_a_reg <= en_a_next;
            w_reg    <= w_next;
        end
        if (rdy_b)
        begin
            en_b_reg  <= en_b_next;
            neg_b_reg <= neg_b_next;
            abs_reg   <= abs_next;
            max01_reg <= max01_next;
            max23_reg <= max23_next;
        end
        if (rdy_c)
        begin
            ctl_c_reg <= ctl_c_next;
            num_c_reg <= num_c_next;
            den_c_reg <= den_c_next;
        end
    end

    assign out_valid = vld_c_reg;
    assign out_ctl   = ctl_c_reg;
    assign out_num   = num_c_reg;
    assign out_den   = den_c_reg;

endmodule

// ----- hdl/mwm_div.sv -----
module mwm_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mwm_pkg::mwm_ctl_t         in_ctl,
    input  mwm_pkg::num_vec_t         in_num,
    input  logic [mwm_pkg::DenW-1:0]  in_den,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mwm_pkg::mwm_ctl_t         out_ctl,
    output mwm_pkg::quot_vec_t        out_quot
);
    import mwm_pkg::*;

    // one restoring step per stage, four lanes sharing one divisor
    logic            vld_reg  [DivSteps];
    logic            vld_next [DivSteps];
    logic            rdy      [DivSteps];
    mwm_ctl_t        ctl_reg  [DivSteps];
    logic [DenW-1:0] den_reg  [DivSteps];
    rem_vec_t        rem_reg  [DivSteps];
    rem_vec_t        rem_next [DivSteps];
    quot_vec_t       low_reg  [DivSteps];
    quot_vec_t       low_next [DivSteps];

    logic            src_vld  [DivSteps];
    mwm_ctl_t        src_ctl  [DivSteps];
    logic [DenW-1:0] src_den  [DivSteps];
    rem_vec_t        src_rem  [DivSteps];
    quot_vec_t       src_low  [DivSteps];

    logic            entry_ok;

    for (genvar k = 0; k < DivSteps; k++)
    begin : g_step
        // stage source: module input or previous stage
        if (k == 0)
        begin : g_first
            assign src_vld[k] = in_valid;
            assign src_ctl[k] = in_ctl;
            assign src_den[k] = in_den;
            for (genvar i = 0; i < Lanes; i++)
            begin : g_lane
                assign src_rem[k][i] = in_num[i][NumW-1:NumW-DenW];
                assign src_low[k][i] = {in_num[i][NumW-DenW-1:0], FracW'(0)};
            end
        end
        else
        begin : g_next
            assign src_vld[k] = vld_reg[k-1];
            assign src_ctl[k] = ctl_reg[k-1];
            assign src_den[k] = den_reg[k-1];
            assign src_rem[k] = rem_reg[k-1];
            assign src_low[k] = low_reg[k-1];
        end

        // ready chain
        if (k == DivSteps - 1)
        begin : g_last
            assign rdy[k] = !vld_reg[k] || out_ready;
        end
        else
        begin : g_mid
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        assign vld_next[k] = rdy[k] ? src_vld[k] : vld_reg[k];

        // bring down one numerator bit, subtract when it fits
        always_comb
        begin
            logic [DenW:0] t;
            logic [DenW:0] diff;
            logic          ge;
            for (int i = 0; i < Lanes; i++)
            begin
                t              = {src_rem[k][i], src_low[k][i][QuotW-1]};
                ge             = t >= {1'b0, src_den[k]};
                diff           = t - {1'b0, src_den[k]};
                rem_next[k][i] = ge ? diff[DenW-1:0] : t[DenW-1:0];
                low_next[k][i] = {src_low[k][i][QuotW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_next[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                ctl_reg[k] <= src_ctl[k];
                den_reg[k] <= src_den[k];
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[DivSteps-1];
    assign out_ctl   = ctl_reg[DivSteps-1];
    assign out_quot  = low_reg[DivSteps-1];

    // every lane's leading numerator bits must sit below the divisor
    always_comb
    begin
        entry_ok = 1'b1;
        for (int i = 0; i < Lanes; i++)
        begin
            if (in_num[i][NumW-1:NumW-DenW] >= in_den)
            begin
                entry_ok = 1'b0;
            end
        end
    end

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> entry_ok)
        else $error("divider entry word would overflow the quotient");

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> (in_den != '0))
        else $error("divider entry word has a zero divisor");

endmodule

// ----- hdl/mwm_back.sv -----
module mwm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  mwm_pkg::mwm_ctl_t         in_ctl,
    input  mwm_pkg::quot_vec_t        in_quot,
    input  logic [mwm_pkg::GainW-1:0] rps_gain,
    input  logic [mwm_pkg::DbW-1:0]   deadband,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mwm_pkg::dir_vec_t         out_dir,
    output mwm_pkg::rps_vec_t         out_rps
);
    import mwm_pkg::*;

    logic             vld_m_reg, vld_m_next, rdy_m;
    logic [Lanes-1:0] mov_reg, mov_next;
    logic [Lanes-1:0] neg_reg, neg_next;
    rps_vec_t         raw_reg, raw_next;

    logic             vld_o_reg, vld_o_next, rdy_o;
    dir_vec_t         dir_reg, dir_next;
    rps_vec_t         rps_reg, rps_next;

    logic             stop_ok, dir_ok, rps_ok;

    assign rdy_o    = !vld_o_reg || out_ready;
    assign rdy_m    = !vld_m_reg || rdy_o;
    assign in_ready = rdy_m;

    assign vld_m_next = rdy_m ? in_valid  : vld_m_reg;
    assign vld_o_next = rdy_o ? vld_m_reg : vld_o_reg;

    // deadband test and gain multiply
    always_comb
    begin
        logic [ProdW-1:0] prod;
        for (int i = 0; i < Lanes; i++)
        begin
            prod        = ProdW'(in_quot[i]) * ProdW'(rps_gain);
            raw_next[i] = prod[ProdW-1:FracW];
            mov_next[i] = in_ctl.en && (in_quot[i] > deadband);
            neg_next[i] = in_ctl.neg[i];
        end
    end

    // saturation and direction coding into the output register
    always_comb
    begin
        for (int i = 0; i < Lanes; i++)
        begin
            if (!mov_reg[i])
            begin
                dir_next[i] = DirStop;
                rps_next[i] = '0;
            end
            else
            begin
                dir_next[i] = neg_reg[i] ? DirRev : DirFwd;
                rps_next[i] = (raw_reg[i] > RpsMax) ? RpsMax : raw_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
            vld_o_reg <= 1'b0;
        end
        else
        begin
            vld_m_reg <= vld_m_next;
            vld_o_reg <= vld_o_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_m)
        begin
            mov_reg <= mov_next;
            neg_reg <= neg_next;
            raw_reg <= raw_next;
        end
        if (rdy_o)
        begin
            dir_reg <= dir_next;
            rps_reg <= rps_next;
        end
    end

    assign out_valid = vld_o_reg;
    assign out_dir   = dir_reg;
    assign out_rps   = rps_reg;

    // lane consistency of the outgoing word
    always_comb
    begin
        stop_ok = 1'b1;
        dir_ok  = 1'b1;
        rps_ok  = 1'b1;
        for (int i = 0; i < Lanes; i++)
        begin
            if (dir_reg[i] == DirStop && rps_reg[i] != '0)
            begin
                stop_ok = 1'b0;
            end
            if (dir_reg[i] != DirStop && dir_reg[i] != DirFwd && dir_reg[i] != DirRev)
            begin
                dir_ok = 1'b0;
            end
            if (rps_reg[i] > RpsMax)
            begin
                rps_ok = 1'b0;
            end
        end
    end

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> stop_ok)
        else $error("stopped wheel carries a nonzero speed");

    a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> dir_ok)
        else $error("wheel direction outside stop, forward, reverse");

    a_rps_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rps_ok)
        else $error("wheel speed above saturation bound");

endmodule

// ----- hdl/mecanum_wheel_mixer.sv -----
// pipeline: an accepted word passes through these registers in order, ending in the output register
// (3 mixing stages, 17 divider stages, gain multiply, output register)
// throughput: one command word per cycle when not stalled; the 17-stage divider takes one quotient bit per stage
// a stalled output holds its word while earlier stages keep filling their empty slots
// reset: all valid bits clear, speed_limit 100, rps_gain 256, deadband 25
module mecanum_wheel_mixer (
    input  logic                             clk,
    input  logic                             rst_n,
    // enable [0], vx [8:1], vy [16:9], vw [24:17], zero fill above
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mwm_pkg::InDataW-1:0]      s_axis_tdata,
    // fl_dir [1:0], fr_dir [3:2], rl_dir [5:4], rr_dir [7:6], fl_rps [32:8],
    // fr_rps [57:33], rl_rps [82:58], rr_rps [107:83], zero fill above
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mwm_pkg::OutDataW-1:0]     m_axis_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mwm_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [mwm_pkg::CfgDataW-1:0]     cfg_data
);
    import mwm_pkg::*;

    logic [LimitW-1:0] speed_limit_reg, speed_limit_next;
    logic [GainW-1:0]  rps_gain_reg, rps_gain_next;
    logic [DbW-1:0]    deadband_reg, deadband_next;

    logic              fr_valid, fr_ready;
    mwm_ctl_t          fr_ctl;
    num_vec_t          fr_num;
    logic [DenW-1:0]   fr_den;

    logic              dv_valid, dv_ready;
    mwm_ctl_t          dv_ctl;
    quot_vec_t         dv_quot;

    dir_vec_t          lane_dir;
    rps_vec_t          lane_rps;

    // config registers, always writable
    assign cfg_ready = 1'b1;

    always_comb
    begin
        speed_limit_next = speed_limit_reg;
        rps_gain_next    = rps_gain_reg;
        deadband_next    = deadband_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CfgSpeedLimit: speed_limit_next = cfg_data[LimitW-1:0];
                CfgRpsGain:    rps_gain_next    = cfg_data[GainW-1:0];
                CfgDeadband:   deadband_next    = cfg_data[DbW-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg <= LimitRst;
            rps_gain_reg    <= GainRst;
            deadband_reg    <= DbRst;
        end
        else
        begin
            speed_limit_reg <= speed_limit_next;
            rps_gain_reg    <= rps_gain_next;
            deadband_reg    <= deadband_next;
        end
    end

    // mixing, magnitude and limit stages
    mwm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_enable   (s_axis_tdata[0]),
        .in_vx       (s_axis_tdata[8:1]),
        .in_vy       (s_axis_tdata[16:9]),
        .in_vw       (s_axis_tdata[24:17]),
        .speed_limit (speed_limit_reg),
        .out_valid   (fr_valid),
        .out_ready   (fr_ready),
        .out_ctl     (fr_ctl),
        .out_num     (fr_num),
        .out_den     (fr_den)
    );

    // proportional scaling divider
    mwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_ctl    (fr_ctl),
        .in_num    (fr_num),
        .in_den    (fr_den),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_ctl   (dv_ctl),
        .out_quot  (dv_quot)
    );

    // deadband, gain and output register
    mwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_ctl    (dv_ctl),
        .in_quot   (dv_quot),
        .rps_gain  (rps_gain_reg),
        .deadband  (deadband_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_dir   (lane_dir),
        .out_rps   (lane_rps)
    );

    // output word packing
    assign m_axis_tdata = {{OutPadW{1'b0}}, lane_rps, lane_dir};

endmodule

// ----- tb/sv/tb_mecanum_wheel_mixer.sv -----
module tb_mecanum_wheel_mixer;
    import mwm_pkg::*;

    localparam int IdlePct      = 31;
    localparam int HoldCycles   = 300;
    localparam int QuietLimit   = 2000;
    localparam int DrainCycles  = 30;
    localparam int PhaseCount   = 9;
    localparam int FixedPhases  = 7;
    localparam int PhaseItems   = 165;
    localparam int DirectedSize = 22;
    localparam int CmdBits      = 1 + 3 * CmdW;

    // one chassis command, enable in the lowest bit
    typedef struct packed {
        logic signed [CmdW-1:0] vw;
        logic signed [CmdW-1:0] vy;
        logic signed [CmdW-1:0] vx;
        logic                   enable;
    } chassis_cmd_t;

    // one set of wheel commands
    typedef struct {
        dir_vec_t dir;
        rps_vec_t rps;
    } wheel_set_t;

    // register settings for each phase: speed limit, gain, deadband
    typedef struct {
        int unsigned limit;
        int unsigned gain;
        int unsigned dband;
    } mixer_setting_t;

    // holds the register copy and the wheel sets still owed by the block
    class wheel_ledger;
        logic [LimitW-1:0] speed_limit;
        logic [GainW-1:0]  rps_gain;
        logic [DbW-1:0]    deadband;
        wheel_set_t        owed[$];
        int unsigned       errors;
        string             lane_names[Lanes];

        function new();
            speed_limit = LimitRst;
            rps_gain    = GainRst;
            deadband    = DbRst;
            errors      = 0;
            lane_names  = '{"front_left", "front_right", "rear_left", "rear_right"};
        endfunction

        function void set_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
            case (idx)
                CfgSpeedLimit: speed_limit = value[LimitW-1:0];
                CfgRpsGain:    rps_gain    = value[GainW-1:0];
                CfgDeadband:   deadband    = value[DbW-1:0];
                default:       ;
            endcase
        endfunction

        // sums and differences, proportional limit, deadband and gain
        function wheel_set_t mix_wheels(chassis_cmd_t cmd);
            int                speed[Lanes];
            int                vx;
            int                vy;
            int                vw;
            int unsigned       peak;
            int unsigned       size_abs;
            longint unsigned   mag;
            longint unsigned   rps;
            wheel_set_t        ws;
            ws.dir = '0;
            ws.rps = '0;
            if (!cmd.enable)
                return ws;
            vx = $signed(cmd.vx);
            vy = $signed(cmd.vy);
            vw = $signed(cmd.vw);
            speed[0] = vx + vy + vw;
            speed[1] = vx - vy - vw;
            speed[2] = vx - vy + vw;
            speed[3] = vx + vy - vw;
            peak = 0;
            for (int i = 0; i < Lanes; i++)
            begin
                size_abs = (speed[i] < 0) ? -speed[i] : speed[i];
                if (size_abs > peak)
                    peak = size_abs;
            end
            for (int i = 0; i < Lanes; i++)
            begin
                mag = (speed[i] < 0) ? -speed[i] : speed[i];
                if (peak > speed_limit)
                    mag = ((mag * speed_limit) << FracW) / peak;
                else
                    mag = mag << FracW;
                if (mag > deadband)
                begin
                    ws.dir[i] = (speed[i] < 0) ? DirRev : DirFwd;
                    rps = (mag * rps_gain) >> FracW;
                    if (rps > RpsMax)
                        rps = RpsMax;
                    ws.rps[i] = rps[RpsW-1:0];
                end
            end
            return ws;
        endfunction

        function void note_command(chassis_cmd_t cmd);
            owed.push_back(mix_wheels(cmd));
        endfunction

        function void check_wheels(logic [OutDataW-1:0] word);
            wheel_set_t      want;
            logic [DirW-1:0] got_dir;
            logic [RpsW-1:0] got_rps;
            if (owed.size() == 0)
            begin
                $error("wheel word arrived with no command outstanding");
                errors++;
                return;
            end
            want = owed.pop_front();
            for (int i = 0; i < Lanes; i++)
            begin
                got_dir = word[i*DirW +: DirW];
                got_rps = word[Lanes*DirW + i*RpsW +: RpsW];
                if (got_dir !== want.dir[i])
                begin
                    $error("%s_dir expected %0d got %0d", lane_names[i],
                           $signed(want.dir[i]), $signed(got_dir));
                    errors++;
                end
                if (got_rps !== want.rps[i])
                begin
                    $error("%s_rps expected %0d got %0d", lane_names[i],
                           want.rps[i], got_rps);
                    errors++;
                end
            end
        endfunction

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [InDataW-1:0]    s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OutDataW-1:0]   m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_idx_t              cfg_index = CfgSpeedLimit;
    logic [CfgDataW-1:0]   cfg_data = '0;

    bit                    steady = 1'b0;
    bit                    hold_request = 1'b0;
    int unsigned           quiet_cycles = 0;
    wheel_ledger           ledger = new();

    // directed commands: enable, vx, vy, vw
    int directed_set[DirectedSize][4] = '{
        '{0, 127, -128, 55}, '{0, 0, 0, 0}, '{1, 0, 0, 0}, '{1, 127, 127, 127},
        '{1, -128, -128, -128}, '{1, 127, -128, 127}, '{1, -128, 127, -128},
        '{1, 100, 0, 0}, '{1, 0, 100, 0}, '{1, 0, 0, 100}, '{1, -100, 0, 0},
        '{1, 0, -100, 0}, '{1, 0, 0, -100}, '{1, 100, 100, 100},
        '{1, -100, -100, -100}, '{1, 10, 20, 30}, '{1, 50, 50, 0}, '{1, 1, 0, 0},
        '{1, -1, 0, 0}, '{1, 127, 0, 0}, '{1, -128, 0, 0}, '{1, 127, 127, -126}
    };

    // fixed phases, then random ones
    mixer_setting_t phase_set[FixedPhases] = '{
        '{1, 256, 0}, '{300, 65535, 0}, '{0, 256, 25}, '{511, 65535, 0},
        '{511, 256, 76800}, '{300, 1, 131071}, '{200, 0, 512}
    };

    mecanum_wheel_mixer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // receiver: random idling, one long hold on request
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HoldCycles - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= steady || ($urandom_range(99) >= IdlePct);
        end
    end

    // check each accepted wheel word
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_wheels(m_axis_tdata);
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic chassis_cmd_t make_cmd(int en, int x, int y, int w);
        chassis_cmd_t c;
        c.enable = en[0];
        c.vx     = x[CmdW-1:0];
        c.vy     = y[CmdW-1:0];
        c.vw     = w[CmdW-1:0];
        return c;
    endfunction

    // mostly the usual command range, some full range, some near zero
    function automatic int random_speed();
        case ($urandom_range(9))
            0, 1:    return $urandom_range(255);
            2:       return int'($urandom_range(6)) - 3;
            default: return int'($urandom_range(200)) - 100;
        endcase
    endfunction

    // valid stays high after the word so a following word goes back to back
    task automatic send_command(chassis_cmd_t cmd);
        while (!steady && $urandom_range(99) < IdlePct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(InDataW-CmdBits){1'b0}}, cmd};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ledger.note_command(cmd);
    endtask

    // stop offering and wait for every owed wheel word
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (ledger.outstanding() != 0)
            @(posedge clk);
    endtask

    // valid stays high across back-to-back register writes
    task automatic write_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.set_register(idx, value);
    endtask

    task automatic apply_settings(mixer_setting_t s);
        write_register(CfgSpeedLimit, CfgDataW'(s.limit));
        write_register(CfgRpsGain, CfgDataW'(s.gain));
        write_register(CfgDeadband, CfgDataW'(s.dband));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        mixer_setting_t s;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed commands under reset values
        s = '{LimitRst, GainRst, DbRst};
        apply_settings(s);
        for (int i = 0; i < DirectedSize; i++)
            send_command(make_cmd(directed_set[i][0], directed_set[i][1],
                                  directed_set[i][2], directed_set[i][3]));
        drain_results();

        // random commands across register settings
        for (int p = 0; p < PhaseCount; p++)
        begin
            if (p < FixedPhases)
                s = phase_set[p];
            else if (p == FixedPhases)
                s = '{$urandom_range(300, 1), $urandom_range(65535), $urandom_range(12800)};
            else
                s = '{$urandom_range(511), $urandom_range(65535), $urandom_range(131071)};
            apply_settings(s);
            steady = (p == 1);
            for (int n = 0; n < PhaseItems; n++)
            begin
                if (p == 3 && n == 20)
                    hold_request = 1'b1;
                if (p == 4 && n == PhaseItems / 2)
                    drain_results();
                send_command(make_cmd(($urandom_range(99) < 90), random_speed(),
                                      random_speed(), random_speed()));
            end
            drain_results();
            steady = 1'b0;
        end

        repeat (DrainCycles) @(posedge clk);
        if (ledger.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/mwm_pkg.sv
hdl/mwm_front.sv
hdl/mwm_div.sv
hdl/mwm_back.sv
hdl/mecanum_wheel_mixer.sv
tb/sv/tb_mecanum_wheel_mixer.sv
